// File: rtl/core/ecou_pkg.sv
`default_nettype none

package ecou_pkg;

  // shared multiplier operand and product widths
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  // vector components, Q1.14
  localparam int VEC_W    = 16;
  // floored cross product component, sum of squares, its root, quotient
  localparam int CROSS_W  = 30;
  localparam int SUMSQ_W  = 58;
  localparam int LEN_W    = 29;
  localparam int QUO_W    = 15;
  localparam int QCNT_W   = $clog2(QUO_W);
  localparam int SQ_ITER  = SUMSQ_W / 2;
  localparam int SCNT_W   = $clog2(SQ_ITER);

  // input modes
  localparam logic [1:0] MODE_LOOK  = 2'd0;
  localparam logic [1:0] MODE_MOVE  = 2'd1;
  localparam logic [1:0] MODE_PLACE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_UP_X      = 3'd0;
  localparam logic [2:0] REG_UP_Y      = 3'd1;
  localparam logic [2:0] REG_UP_Z      = 3'd2;
  localparam logic [2:0] REG_PITCH_GAIN = 3'd3;
  localparam logic [2:0] REG_YAW_GAIN  = 3'd4;

  // sine polynomial coefficients and fixed-point constants
  localparam logic [16:0] SIN_A   = 17'd25736;
  localparam logic [16:0] SIN_B   = 17'd10512;
  localparam logic [16:0] SIN_C   = 17'd1160;
  localparam logic [16:0] Q14_ONE = 17'd16384;
  localparam logic [16:0] STEP_K  = 17'd1966;
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF    = 32'h8000_0000;

  typedef logic signed [VEC_W-1:0] vec_t;

endpackage

`default_nettype wire

// File: rtl/core/ecou_mul.sv
`default_nettype none

module ecou_mul
  import ecou_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  a,
  input  wire logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0]      p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

// File: rtl/core/ecou_isqrt.sv
`default_nettype none

module ecou_isqrt
  import ecou_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SUMSQ_W-1:0] radicand,
  output logic [LEN_W-1:0]        root,
  output logic                    done
);

  localparam logic [SUMSQ_W-1:0] BIT0 = {2'b01, {(SUMSQ_W-2){1'b0}}};

  logic [SUMSQ_W-1:0] v_r, r_r, bit_r;
  logic [SCNT_W-1:0]  cnt_r;
  logic               run_r, done_r;
  logic [SUMSQ_W-1:0] trial;

  assign trial = r_r + bit_r;
  assign root  = r_r[LEN_W-1:0];
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r   <= radicand;
        r_r   <= '0;
        bit_r <= BIT0;
        cnt_r <= SCNT_W'(SQ_ITER - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ecou_div.sv
`default_nettype none

module ecou_div
  import ecou_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [LEN_W-1:0] dividend,
  input  wire logic [LEN_W-1:0] divisor,
  output logic [QUO_W-1:0]      quotient,
  output logic                  done
);

  // dividend never exceeds divisor, so quotient of dividend * 2^14 fits QUO_W bits
  logic [LEN_W:0]     rem_r;
  logic [LEN_W-1:0]   den_r;
  logic [QUO_W-1:0]   q_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               run_r, done_r;
  logic               ge;
  logic [LEN_W:0]     diff;

  assign ge       = rem_r >= {1'b0, den_r};
  assign diff     = rem_r - {1'b0, den_r};
  assign quotient = q_r;
  assign done     = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= {1'b0, dividend};
        den_r <= divisor;
        q_r   <= '0;
        cnt_r <= QCNT_W'(QUO_W - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= ge ? {diff[LEN_W-1:0], 1'b0} : {rem_r[LEN_W-1:0], 1'b0};
        q_r   <= {q_r[QUO_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/euler_camera_orientation_update_unit.sv
`default_nettype none

// First-person camera engine. Each transaction looks (mouse deltas scaled by the gains
// are subtracted from pitch and yaw), places (angles and position loaded) or moves
// (forward and right, scaled by 0.03 and the speeds, added to the saturating
// position), and returns one result with the pose after the update. Look and place
// rebuild forward, right and up through one shared 33x33 multiplier, a bit-pair
// square root and a restoring divider. The block takes one transaction at a time:
// in_ready is high only while it is idle. Register writes take effect on the next
// look or place.
module euler_camera_orientation_update_unit
  import ecou_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int POS_BITS   = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [15:0] in_delta_x,
  input  wire logic signed [15:0] in_delta_y,
  input  wire logic signed [15:0] in_speed_forward,
  input  wire logic signed [15:0] in_speed_side,
  input  wire logic [15:0]        in_place_pitch,
  input  wire logic [15:0]        in_place_yaw,
  input  wire logic signed [31:0] in_place_x,
  input  wire logic signed [31:0] in_place_y,
  input  wire logic signed [31:0] in_place_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [15:0]      out_fwd_x,
  output logic signed [15:0]      out_fwd_y,
  output logic signed [15:0]      out_fwd_z,
  output logic signed [15:0]      out_right_x,
  output logic signed [15:0]      out_right_y,
  output logic signed [15:0]      out_right_z,
  output logic signed [15:0]      out_up_x,
  output logic signed [15:0]      out_up_y,
  output logic signed [15:0]      out_up_z,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);

  localparam int EXT_W = ((POS_BITS > 32) ? POS_BITS : 32) + 2;
  localparam logic signed [EXT_W-1:0] POS_HI =
    {{(EXT_W-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] POS_LO = -POS_HI - 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK_P, ST_LOOK_Y, ST_LOOK_W, ST_SIN, ST_FWD0, ST_FWD1, ST_FWD2,
    ST_CROSS, ST_SQUARE, ST_SQRT, ST_DIV, ST_MOVE, ST_DONE
  } state_t;

  state_t state_r;

  // configuration
  vec_t        wu_r [3];
  logic [15:0] pitch_gain_r, yaw_gain_r;

  // pose
  logic [ANGLE_BITS-1:0]     pitch_r, yaw_r;
  logic signed [POS_BITS-1:0] pos_r [3];
  vec_t                      f_r [3], rv_r [3], uv_r [3];

  // captured transaction fields
  logic signed [15:0] dx_r, dy_r, sf_r, ss_r;

  // working registers
  logic [2:0]                step_r;
  logic [1:0]                sidx_r, mi_r, didx_r;
  logic                      pass_r;
  logic [14:0]               z2_r;
  logic signed [16:0]        sin_r [4];
  logic signed [MUL_W-1:0]   acc_r;
  logic signed [CROSS_W-1:0] c_r [3];
  logic [SUMSQ_W-1:0]        sum_r;

  // output registers
  logic               out_valid_r;
  logic signed [31:0] o_pos_r [3];
  vec_t               o_f_r [3], o_r_r [3], o_u_r [3];

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     sq_start, sq_done, dv_start, dv_done;
  logic [LEN_W-1:0]         sq_root, dv_mag;
  logic [QUO_W-1:0]         dv_q;
  logic [1:0]               dv_sel;
  logic [SUMSQ_W-1:0]       sum_fin;

  ecou_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  ecou_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_fin),
    .root(sq_root), .done(sq_done)
  );

  ecou_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_mag),
    .divisor(sq_root), .quotient(dv_q), .done(dv_done)
  );

  // sine argument from the current angle
  logic [ANGLE_BITS-1:0] ang;
  logic [31:0]           u_full, u_mag;
  logic                  s_neg;
  logic [14:0]           z;
  logic [16:0]           p14, t1, t2, s_mag;
  vec_t                  bvec [3];
  logic signed [33:0]    cdiff;
  logic [2:0]            prev;
  logic signed [CROSS_W-1:0] c_sel;
  logic signed [21:0]    mv_delta;
  logic signed [EXT_W-1:0] mv_sum;
  vec_t                  q_signed;

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] s;
    begin
      s = v;
      if (v > POS_HI) s = POS_HI;
      else if (v < POS_LO) s = POS_LO;
      sat_pos = s[POS_BITS-1:0];
    end
  endfunction

  always_comb begin
    ang    = sidx_r[1] ? yaw_r : pitch_r;
    u_full = {ang, {(32-ANGLE_BITS){1'b0}}} + (sidx_r[0] ? QUARTER : 32'd0);
    s_neg  = u_full[31];
    u_mag  = {1'b0, u_full[30:0]};
    if (u_mag > QUARTER) u_mag = HALF - u_mag;
    z      = u_mag[30:16];
    p14    = mul_p[30:14];
    t1     = SIN_B - p14;
    t2     = SIN_A - p14;
    s_mag  = (p14 > Q14_ONE) ? Q14_ONE : p14;
    prev   = step_r - 3'd1;
    cdiff  = {acc_r[MUL_W-1], acc_r} - {mul_p[MUL_W-1], mul_p[MUL_W-1:0]};
    sum_fin = sum_r + mul_p[SUMSQ_W-1:0];
    mv_delta = mul_p[43:22];
    mv_sum = {{(EXT_W-POS_BITS){pos_r[mi_r][POS_BITS-1]}}, pos_r[mi_r]}
             + {{(EXT_W-22){mv_delta[21]}}, mv_delta};
    for (int i = 0; i < 3; i++) bvec[i] = pass_r ? rv_r[i] : wu_r[i];
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LOOK_P: begin mul_a = MUL_W'(dy_r); mul_b = MUL_W'(pitch_gain_r); end
      ST_LOOK_Y: begin mul_a = MUL_W'(dx_r); mul_b = MUL_W'(yaw_gain_r); end
      ST_SIN: begin
        case (step_r)
          3'd0: begin mul_a = MUL_W'(z); mul_b = MUL_W'(z); end
          3'd1: begin mul_a = MUL_W'(SIN_C); mul_b = MUL_W'(p14); end
          3'd2: begin mul_a = MUL_W'(z2_r); mul_b = MUL_W'(t1); end
          3'd3: begin mul_a = MUL_W'(z); mul_b = MUL_W'(t2); end
          default: ;
        endcase
      end
      ST_FWD0: begin mul_a = MUL_W'(sin_r[1]); mul_b = MUL_W'(sin_r[2]); end
      ST_FWD1: begin mul_a = MUL_W'(sin_r[1]); mul_b = MUL_W'(sin_r[3]); end
      ST_CROSS: begin
        case (step_r)
          3'd0: begin mul_a = MUL_W'(f_r[1]); mul_b = MUL_W'(bvec[2]); end
          3'd1: begin mul_a = MUL_W'(f_r[2]); mul_b = MUL_W'(bvec[1]); end
          3'd2: begin mul_a = MUL_W'(f_r[2]); mul_b = MUL_W'(bvec[0]); end
          3'd3: begin mul_a = MUL_W'(f_r[0]); mul_b = MUL_W'(bvec[2]); end
          3'd4: begin mul_a = MUL_W'(f_r[0]); mul_b = MUL_W'(bvec[1]); end
          3'd5: begin mul_a = MUL_W'(f_r[1]); mul_b = MUL_W'(bvec[0]); end
          default: ;
        endcase
      end
      ST_SQUARE: begin
        case (step_r)
          3'd0: begin mul_a = MUL_W'(c_r[0]); mul_b = MUL_W'(c_r[0]); end
          3'd1: begin mul_a = MUL_W'(c_r[1]); mul_b = MUL_W'(c_r[1]); end
          3'd2: begin mul_a = MUL_W'(c_r[2]); mul_b = MUL_W'(c_r[2]); end
          default: ;
        endcase
      end
      ST_MOVE: begin
        case (step_r)
          3'd0: begin mul_a = MUL_W'(f_r[mi_r]); mul_b = MUL_W'(sf_r); end
          3'd1: begin mul_a = MUL_W'(rv_r[mi_r]); mul_b = MUL_W'(ss_r); end
          3'd2: begin mul_a = acc_r + mul_p[MUL_W-1:0]; mul_b = MUL_W'(STEP_K); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // root and divider control
  always_comb begin
    sq_start = (state_r == ST_SQUARE) && (step_r == 3'd3) && (sum_fin != '0);
    dv_start = ((state_r == ST_SQRT) && sq_done) ||
               ((state_r == ST_DIV) && dv_done && (didx_r != 2'd2));
    dv_sel   = ((state_r == ST_DIV) && (didx_r != 2'd2)) ? didx_r + 2'd1 : 2'd0;
    c_sel    = c_r[dv_sel];
    dv_mag   = c_sel[CROSS_W-1] ? LEN_W'(-c_sel) : LEN_W'(c_sel);
    q_signed = c_r[didx_r][CROSS_W-1] ? -VEC_W'(dv_q) : VEC_W'(dv_q);
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_pos_x = o_pos_r[0];
  assign out_pos_y = o_pos_r[1];
  assign out_pos_z = o_pos_r[2];
  assign out_fwd_x = o_f_r[0];
  assign out_fwd_y = o_f_r[1];
  assign out_fwd_z = o_f_r[2];
  assign out_right_x = o_r_r[0];
  assign out_right_y = o_r_r[1];
  assign out_right_z = o_r_r[2];
  assign out_up_x = o_u_r[0];
  assign out_up_y = o_u_r[1];
  assign out_up_z = o_u_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      wu_r[0]      <= 16'sd0;
      wu_r[1]      <= 16'sd16384;
      wu_r[2]      <= 16'sd0;
      pitch_gain_r <= 16'd256;
      yaw_gain_r   <= 16'd256;
      pitch_r      <= '0;
      yaw_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        f_r[i]   <= '0;
        rv_r[i]  <= '0;
        uv_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_UP_X:       wu_r[0] <= cfg_wdata;
          REG_UP_Y:       wu_r[1] <= cfg_wdata;
          REG_UP_Z:       wu_r[2] <= cfg_wdata;
          REG_PITCH_GAIN: pitch_gain_r <= cfg_wdata;
          REG_YAW_GAIN:   yaw_gain_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            dx_r <= in_delta_x;
            dy_r <= in_delta_y;
            sf_r <= in_speed_forward;
            ss_r <= in_speed_side;
            step_r <= '0;
            sidx_r <= '0;
            mi_r   <= '0;
            case (in_mode)
              MODE_LOOK: state_r <= ST_LOOK_P;
              MODE_MOVE: state_r <= ST_MOVE;
              MODE_PLACE: begin
                pitch_r  <= ANGLE_BITS'(in_place_pitch);
                yaw_r    <= ANGLE_BITS'(in_place_yaw);
                pos_r[0] <= sat_pos({{(EXT_W-32){in_place_x[31]}}, in_place_x});
                pos_r[1] <= sat_pos({{(EXT_W-32){in_place_y[31]}}, in_place_y});
                pos_r[2] <= sat_pos({{(EXT_W-32){in_place_z[31]}}, in_place_z});
                state_r  <= ST_SIN;
              end
              default: state_r <= ST_DONE;
            endcase
          end
        end

        ST_LOOK_P: state_r <= ST_LOOK_Y;

        ST_LOOK_Y: begin
          pitch_r <= pitch_r - mul_p[ANGLE_BITS+7:8];
          state_r <= ST_LOOK_W;
        end

        ST_LOOK_W: begin
          yaw_r   <= yaw_r - mul_p[ANGLE_BITS+7:8];
          state_r <= ST_SIN;
        end

        ST_SIN: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd1: z2_r <= p14[14:0];
            3'd4: begin
              sin_r[sidx_r] <= s_neg ? -$signed(s_mag) : $signed(s_mag);
              step_r <= '0;
              sidx_r <= sidx_r + 2'd1;
              if (sidx_r == 2'd3) state_r <= ST_FWD0;
            end
            default: ;
          endcase
        end

        ST_FWD0: state_r <= ST_FWD1;

        ST_FWD1: begin
          f_r[0]  <= mul_p[29:14];
          state_r <= ST_FWD2;
        end

        ST_FWD2: begin
          f_r[2]  <= mul_p[29:14];
          f_r[1]  <= sin_r[0][VEC_W-1:0];
          pass_r  <= 1'b0;
          step_r  <= '0;
          state_r <= ST_CROSS;
        end

        // six products, paired into three floored differences
        ST_CROSS: begin
          step_r <= step_r + 3'd1;
          if (step_r != 3'd0) begin
            if (!prev[0]) acc_r <= mul_p[MUL_W-1:0];
            else c_r[prev[2:1]] <= cdiff[CROSS_W+1:2];
          end
          if (step_r == 3'd6) begin
            step_r  <= '0;
            sum_r   <= '0;
            state_r <= ST_SQUARE;
          end
        end

        ST_SQUARE: begin
          step_r <= step_r + 3'd1;
          if (step_r != 3'd0) sum_r <= sum_fin;
          if (step_r == 3'd3) begin
            if (sum_fin == '0) begin
              // degenerate cross product: zero vector
              for (int i = 0; i < 3; i++) begin
                if (!pass_r) rv_r[i] <= '0;
                else uv_r[i] <= '0;
              end
              step_r <= '0;
              if (!pass_r) begin
                pass_r  <= 1'b1;
                state_r <= ST_CROSS;
              end else begin
                state_r <= ST_DONE;
              end
            end else begin
              state_r <= ST_SQRT;
            end
          end
        end

        ST_SQRT: begin
          if (sq_done) begin
            didx_r  <= '0;
            state_r <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (dv_done) begin
            if (!pass_r) rv_r[didx_r] <= q_signed;
            else uv_r[didx_r] <= q_signed;
            didx_r <= didx_r + 2'd1;
            if (didx_r == 2'd2) begin
              step_r <= '0;
              if (!pass_r) begin
                pass_r  <= 1'b1;
                state_r <= ST_CROSS;
              end else begin
                state_r <= ST_DONE;
              end
            end
          end
        end

        ST_MOVE: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd1: acc_r <= mul_p[MUL_W-1:0];
            3'd3: begin
              pos_r[mi_r] <= sat_pos(mv_sum);
              step_r <= '0;
              mi_r   <= mi_r + 2'd1;
              if (mi_r == 2'd2) state_r <= ST_DONE;
            end
            default: ;
          endcase
        end

        ST_DONE: begin
          // hold until the previous result has been taken
          if (!out_valid_r || out_ready) begin
            for (int i = 0; i < 3; i++) begin
              o_pos_r[i] <= 32'({{(EXT_W-POS_BITS){pos_r[i][POS_BITS-1]}}, pos_r[i]});
              o_f_r[i]   <= f_r[i];
              o_r_r[i]   <= rv_r[i];
              o_u_r[i]   <= uv_r[i];
            end
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb
  import ecou_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         mode;
    logic signed [15:0] dx, dy, sf, ss;
    logic [15:0]        pp, py;
    logic signed [31:0] px, py_pos, pz;
  } move_t;

  typedef struct {
    logic signed [31:0] pos[3];
    logic signed [15:0] vec[9];
  } pose_t;

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // camera state mirror
  class pose_scoreboard;
    logic signed [15:0] up_vec[3];
    logic [15:0]        p_gain, y_gain;
    logic [15:0]        pitch, yaw;
    longint             pos[3];
    longint             basis[9];
    pose_t              pending[$];

    function new();
      up_vec = '{16'sd0, 16'sd16384, 16'sd0};
      p_gain = 256;
      y_gain = 256;
      pitch = 0;
      yaw = 0;
      foreach (pos[i]) pos[i] = 0;
      foreach (basis[i]) basis[i] = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [15:0] v);
      case (idx)
        REG_UP_X:       up_vec[0] = v;
        REG_UP_Y:       up_vec[1] = v;
        REG_UP_Z:       up_vec[2] = v;
        REG_PITCH_GAIN: p_gain = v;
        REG_YAW_GAIN:   y_gain = v;
        default: ;
      endcase
    endfunction

    function longint sine(input logic [31:0] u);
      logic        neg;
      logic [31:0] a;
      longint      z, z2, t, r;
      neg = u[31];
      a = {1'b0, u[30:0]};
      if (a > QUARTER) a = HALF - a;
      z = a >> 16;
      z2 = (z * z) >> 14;
      t = 10512 - ((1160 * z2) >> 14);
      t = 25736 - ((z2 * t) >> 14);
      r = (z * t) >> 14;
      if (r > 16384) r = 16384;
      return neg ? -r : r;
    endfunction

    function longint root(input longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >>> 1) + b;
        end else r = r >>> 1;
        b = b >>> 2;
      end
      return r;
    endfunction

    function void unit_cross(input longint a[3], input longint b[3], output longint o[3]);
      longint c[3];
      longint s, len, m;
      c[0] = (a[1] * b[2] - a[2] * b[1]) >>> 2;
      c[1] = (a[2] * b[0] - a[0] * b[2]) >>> 2;
      c[2] = (a[0] * b[1] - a[1] * b[0]) >>> 2;
      s = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
      if (s == 0) begin
        o = '{0, 0, 0};
        return;
      end
      len = root(s);
      for (int i = 0; i < 3; i++) begin
        m = c[i] < 0 ? -c[i] : c[i];
        m = (m * 16384) / len;
        o[i] = c[i] < 0 ? -m : m;
      end
    endfunction

    function void orient();
      longint sp, cp, sy, cy;
      longint f[3], w[3], r[3], u[3];
      sp = sine({pitch, 16'h0});
      cp = sine({pitch, 16'h0} + QUARTER);
      sy = sine({yaw, 16'h0});
      cy = sine({yaw, 16'h0} + QUARTER);
      f[0] = (cp * sy) >>> 14;
      f[1] = sp;
      f[2] = (cp * cy) >>> 14;
      foreach (w[i]) w[i] = up_vec[i];
      unit_cross(f, w, r);
      unit_cross(f, r, u);
      for (int i = 0; i < 3; i++) begin
        basis[i] = f[i];
        basis[3 + i] = r[i];
        basis[6 + i] = u[i];
      end
    endfunction

    function longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note(input move_t m);
      pose_t  e;
      longint d;
      case (m.mode)
        MODE_LOOK: begin
          pitch = pitch - 16'((longint'(m.dy) * longint'(p_gain)) >>> 8);
          yaw = yaw - 16'((longint'(m.dx) * longint'(y_gain)) >>> 8);
          orient();
        end
        MODE_MOVE: begin
          for (int i = 0; i < 3; i++) begin
            d = ((basis[i] * m.sf + basis[3 + i] * m.ss) * 1966) >>> 22;
            pos[i] = clamp32(pos[i] + d);
          end
        end
        MODE_PLACE: begin
          pitch = m.pp;
          yaw = m.py;
          pos[0] = m.px;
          pos[1] = m.py_pos;
          pos[2] = m.pz;
          orient();
        end
        default: ;
      endcase
      foreach (e.pos[i]) e.pos[i] = pos[i][31:0];
      foreach (e.vec[i]) e.vec[i] = basis[i][15:0];
      pending.push_back(e);
    endfunction

    task check(input pose_t got);
      pose_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("result with nothing pending at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      foreach (e.pos[i])
        if (got.pos[i] !== e.pos[i]) report($sformatf("pos[%0d]", i), got.pos[i], e.pos[i]);
      foreach (e.vec[i])
        if (got.vec[i] !== e.vec[i]) report($sformatf("vec[%0d]", i), got.vec[i], e.vec[i]);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_mode = 0;
  logic signed [15:0] in_delta_x = 0, in_delta_y = 0, in_speed_forward = 0, in_speed_side = 0;
  logic [15:0] in_place_pitch = 0, in_place_yaw = 0;
  logic signed [31:0] in_place_x = 0, in_place_y = 0, in_place_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_fwd_x, out_fwd_y, out_fwd_z, out_right_x, out_right_y, out_right_z;
  logic signed [15:0] out_up_x, out_up_y, out_up_z;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_wdata = 0;

  euler_camera_orientation_update_unit dut (.*);

  always #5 clk = ~clk;

  pose_scoreboard sb = new();
  longint cycles = 0;
  bit stall_free = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: stretches of steady accept, else random stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      pose_t g;
      g.pos = '{out_pos_x, out_pos_y, out_pos_z};
      g.vec = '{out_fwd_x, out_fwd_y, out_fwd_z, out_right_x, out_right_y, out_right_z,
                out_up_x, out_up_y, out_up_z};
      sb.check(g);
    end
    if (cycles % 512 == 0) stall_free <= $urandom_range(0, 3) == 0;
    out_ready <= stall_free ? 1'b1 : ($urandom_range(0, 99) < 60);
  end

  task automatic send(input move_t m);
    in_valid <= 1;
    in_mode <= m.mode;
    in_delta_x <= m.dx;
    in_delta_y <= m.dy;
    in_speed_forward <= m.sf;
    in_speed_side <= m.ss;
    in_place_pitch <= m.pp;
    in_place_yaw <= m.py;
    in_place_x <= m.px;
    in_place_y <= m.py_pos;
    in_place_z <= m.pz;
    do @(posedge clk); while (!in_ready);
    sb.note(m);
  endtask

  task automatic idle_cycles(input int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic move_t rand_move(input int bias);
    move_t m;
    int    r;
    r = $urandom_range(0, 99);
    m.mode = r < 40 ? MODE_LOOK : r < 75 ? MODE_MOVE : r < 97 ? MODE_PLACE : 2'd3;
    m.dx = bias ? $urandom : $signed(16'($urandom_range(0, 80))) - 40;
    m.dy = bias ? $urandom : $signed(16'($urandom_range(0, 80))) - 40;
    m.sf = $urandom;
    m.ss = $urandom;
    m.pp = $urandom;
    m.py = $urandom;
    m.px = bias ? $urandom : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    m.py_pos = $urandom;
    m.pz = bias ? $urandom : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    return m;
  endfunction

  function automatic move_t mk(input logic [1:0] md, input int a, input int b,
                               input logic [31:0] p);
    move_t m;
    m = '{md, a, b, a, b, a, b, p, p, p};
    return m;
  endfunction

  initial begin
    logic [15:0] ups[4][3];
    ups = '{'{0, 16384, 0}, '{16384, 0, 0}, '{-16384, -16384, 16384}, '{0, 0, -16384}};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // move before any orientation: no travel
    send(mk(MODE_MOVE, 32767, -32768, 0));
    send(mk(2'd3, 1, 1, 0));
    send(mk(MODE_LOOK, 0, 0, 0));
    send(mk(MODE_LOOK, 32767, -32768, 0));
    send(mk(MODE_LOOK, -32768, 32767, 0));
    send(mk(MODE_PLACE, 16'h4000, 0, 32'h7fffffff));
    send(mk(MODE_MOVE, 32767, 32767, 0));
    send(mk(MODE_PLACE, 16'hc000, 16'hffff, 32'h80000000));
    send(mk(MODE_MOVE, -32768, -32768, 0));
    send(mk(MODE_PLACE, 16'h8000, 16'h4000, 32'h0));
    send(mk(MODE_MOVE, 32767, -32768, 0));
    drain();
    // world up along forward: degenerate right and up
    write_reg(REG_UP_Y, 0);
    write_reg(REG_UP_Z, 16384);
    send(mk(MODE_PLACE, 0, 0, 32'h10000));
    send(mk(MODE_MOVE, 1000, 1000, 0));
    drain();
    write_reg(REG_UP_X, 16'h8000);
    write_reg(REG_UP_Y, 16'h7fff);
    write_reg(3'd7, 16'h1234);
    write_reg(REG_PITCH_GAIN, 16'hffff);
    write_reg(REG_YAW_GAIN, 0);
    send(mk(MODE_LOOK, 32767, -32768, 0));
    send(mk(MODE_LOOK, -1, 1, 0));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_UP_X, ph < 4 ? ups[ph][0] : 16'($urandom_range(0, 32768)) - 16384);
      write_reg(REG_UP_Y, ph < 4 ? ups[ph][1] : 16'($urandom_range(0, 32768)) - 16384);
      write_reg(REG_UP_Z, ph < 4 ? ups[ph][2] : 16'($urandom_range(0, 32768)) - 16384);
      write_reg(REG_PITCH_GAIN, ph == 1 ? 16'hffff : ph == 2 ? 0 : $urandom);
      write_reg(REG_YAW_GAIN, ph == 1 ? 0 : ph == 2 ? 16'hffff : $urandom_range(0, 1024));
      for (int n = 0; n < 100;) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++, n++) send(rand_move($urandom_range(0, 3) == 0));
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 300));
      end
      drain();
    end

    if (errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

`default_nettype wire
